>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the reset is released.
`define LBPC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LBPC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lbpc_pkg.sv
`timescale 1ns / 1ps

package lbpc_pkg;

  localparam int MaxWidthDefault  = 1024;
  localparam int MaxHeightDefault = 1024;

  localparam int PixelW    = 8;
  localparam int CodeW     = 8;
  localparam int IndexW    = 10;
  localparam int CfgW      = 11;
  localparam int CfgIndexW = 1;

  localparam logic [CfgW-1:0] CfgSizeReset = 11'd1024;

  localparam logic [CfgIndexW-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CfgIndexW-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // One pixel that waits for its line data.
  typedef struct packed {
    logic              has_result;
    logic              last;
    logic [IndexW-1:0] row_idx;
    logic [IndexW-1:0] col_idx;
    logic [PixelW-1:0] pixel;
  } stage_t;

endpackage

>>> rtl/lbpc_pix_if.sv
`timescale 1ns / 1ps

interface lbpc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [lbpc_pkg::PixelW-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> rtl/lbpc_code_if.sv
`timescale 1ns / 1ps

interface lbpc_code_if;
  logic                        valid;
  logic                        ready;
  logic [lbpc_pkg::CodeW-1:0]  code;
  logic [lbpc_pkg::IndexW-1:0] row_index;
  logic [lbpc_pkg::IndexW-1:0] col_index;
  logic                        frame_last;

  modport source (output valid, output code, output row_index, output col_index,
                  output frame_last, input ready);
  modport sink   (input valid, input code, input row_index, input col_index,
                  input frame_last, output ready);
endinterface

>>> rtl/lbp_code_image.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// 3x3 local binary pattern over a padded raster stream. The block takes one
// 8-bit pixel per clock of a frame of (image_height+2) rows of
// (image_width+2) pixels that already carries a one-pixel border, and for
// every interior pixel returns one code: bit k is set when neighbour k is
// strictly greater than the centre, clockwise from the top-left neighbour
// (bit 0) to the left neighbour (bit 7), together with the interior row and
// column of the centre and a frame_last mark on the bottom-right pixel.
// Border pixels in the first two padded rows and columns produce no
// transaction on the output. A pixel with frame_start set restarts the frame
// at the top-left border position; otherwise frames follow one another
// seamlessly. Sizes above MAX_WIDTH or MAX_HEIGHT are clipped to them, and
// registers are to be written only while the block is idle. Throughput is one
// pixel per clock while the output is not stalled; an accepted pixel passes
// through the synchronous read of the line store, which keeps the two
// previous padded rows side by side in one word per column, and then the
// output register. The line store needs no clearing after reset.
module lbp_code_image #(
  parameter int MAX_WIDTH  = lbpc_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = lbpc_pkg::MaxHeightDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbpc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [lbpc_pkg::CfgW-1:0]        cfg_data_i,
  lbpc_pix_if.sink                         pix_i,
  lbpc_code_if.source                      code_o
);

  localparam int Depth  = MAX_WIDTH + 2;
  localparam int AddrW  = $clog2(Depth);
  localparam int ColW   = $clog2(MAX_WIDTH + 3);
  localparam int RowW   = $clog2(MAX_HEIGHT + 3);
  localparam int CfgW   = lbpc_pkg::CfgW;
  localparam int PixW   = lbpc_pkg::PixelW;
  localparam int IdxW   = lbpc_pkg::IndexW;
  localparam int ColCmpW = (ColW > CfgW) ? ColW : CfgW;
  localparam int RowCmpW = (RowW > CfgW) ? RowW : CfgW;

  // Configuration registers.
  logic [CfgW-1:0] width_q;
  logic [CfgW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lbpc_pkg::CfgSizeReset;
      height_q <= lbpc_pkg::CfgSizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbpc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        lbpc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Padded frame size after clipping to the line store.
  logic [ColCmpW-1:0] width_ext;
  logic [RowCmpW-1:0] height_ext;
  logic [ColW-1:0]    pad_w;
  logic [RowW-1:0]    pad_h;

  always_comb begin
    width_ext  = ColCmpW'(width_q);
    height_ext = RowCmpW'(height_q);
    if (width_ext > ColCmpW'(MAX_WIDTH)) begin
      width_ext = ColCmpW'(MAX_WIDTH);
    end
    if (height_ext > RowCmpW'(MAX_HEIGHT)) begin
      height_ext = RowCmpW'(MAX_HEIGHT);
    end
    pad_w = ColW'(width_ext) + ColW'(2);
    pad_h = RowW'(height_ext) + RowW'(2);
  end

  // Position counters of the next pixel in the padded frame.
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic            in_acc;

  always_comb begin
    col_cur = pix_i.frame_start ? '0 : col_q;
    row_cur = pix_i.frame_start ? '0 : row_q;
    if (col_cur >= pad_w) begin
      col_cur = '0;
    end
    if (row_cur >= pad_h) begin
      row_cur = '0;
    end
    col_d = col_cur + ColW'(1);
    row_d = row_cur;
    if (col_d >= pad_w) begin
      col_d = '0;
      row_d = row_cur + RowW'(1);
      if (row_d >= pad_h) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage holding the pixel while its line word is read.
  lbpc_pkg::stage_t s1_q, s1_d;
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_adv;
  logic             out_free;
  logic             out_valid_q;

  always_comb begin
    s1_d.has_result = (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
    s1_d.last       = (row_cur == pad_h - RowW'(1)) && (col_cur == pad_w - ColW'(1));
    s1_d.row_idx    = IdxW'(row_cur - RowW'(2));
    s1_d.col_idx    = IdxW'(col_cur - ColW'(2));
    s1_d.pixel      = pix_i.pixel;
  end

  assign out_free    = !out_valid_q || code_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_q.has_result || out_free);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc || s1_adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= s1_d;
      s1_addr_q <= col_cur[AddrW-1:0];
    end
  end

  // Line store: upper row in the high byte, middle row in the low byte.
  logic [2*PixW-1:0] line_rd;
  logic [PixW-1:0]   top;
  logic [PixW-1:0]   mid;

  lbpc_line_store #(
    .Depth (Depth)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur[AddrW-1:0]),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid, s1_q.pixel}),
    .rd_data_o (line_rd)
  );

  assign top = line_rd[2*PixW-1:PixW];
  assign mid = line_rd[PixW-1:0];

  // Window of the two columns to the left: 0..2 is column c-1 and 3..5 is
  // column c-2, each top to bottom.
  logic [PixW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= s1_q.pixel;
    end
  end

  // The centre is the middle pixel of column c-1.
  logic [lbpc_pkg::CodeW-1:0] code_d;

  always_comb begin
    code_d[0] = win_q[3]   > win_q[1];
    code_d[1] = win_q[0]   > win_q[1];
    code_d[2] = top        > win_q[1];
    code_d[3] = mid        > win_q[1];
    code_d[4] = s1_q.pixel > win_q[1];
    code_d[5] = win_q[2]   > win_q[1];
    code_d[6] = win_q[5]   > win_q[1];
    code_d[7] = win_q[4]   > win_q[1];
  end

  // Output register.
  logic [lbpc_pkg::CodeW-1:0] out_code_q;
  logic [IdxW-1:0]            out_row_q;
  logic [IdxW-1:0]            out_col_q;
  logic                       out_last_q;
  logic                       out_load;

  assign out_load = s1_adv && s1_q.has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (code_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= code_d;
      out_row_q  <= s1_q.row_idx;
      out_col_q  <= s1_q.col_idx;
      out_last_q <= s1_q.last;
    end
  end

  assign code_o.valid      = out_valid_q;
  assign code_o.code       = out_code_q;
  assign code_o.row_index  = out_row_q;
  assign code_o.col_index  = out_col_q;
  assign code_o.frame_last = out_last_q;

  // A new output transaction always comes from a stage item with a result.
  `LBPC_ASSERT(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q) |-> $past(out_load), "output rose without a stage result")
  // An accepted pixel always occupies the read stage on the next cycle.
  `LBPC_ASSERT(a_acc_fills_stage, clk_i, rst_ni, in_acc |=> s1_valid_q, "accepted pixel lost from the read stage")
  // A stage item with a result never leaves while the output is blocked.
  `LBPC_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !code_o.ready) |-> !out_load, "pending output overwritten")
  // The reset clears the output valid, so nothing is offered on the output.
  `LBPC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_q, "output valid during reset")

endmodule

>>> rtl/lbpc_line_store.sv
`timescale 1ns / 1ps

// Line store: one word per padded column holding the two previous rows.
// A read and a write to the same column on the same edge return the new data.
module lbpc_line_store #(
  parameter int Depth = lbpc_pkg::MaxWidthDefault + 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(Depth)-1:0]       rd_addr_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(Depth)-1:0]       wr_addr_i,
  input  logic [2*lbpc_pkg::PixelW-1:0]  wr_data_i,
  output logic [2*lbpc_pkg::PixelW-1:0]  rd_data_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int WordW = 2 * lbpc_pkg::PixelW;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == AddrW'(rd_addr_i));
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule
